// ===== rtl/core/ssdwb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdwb_pkg
// Shared types and constants for the write buffer with read forwarding.
// ----------------------------------------------------------------------------
package ssdwb_pkg;

  localparam int unsigned AddrW      = 16;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountW     = 4;
  localparam int unsigned InDataW    = 56;
  localparam int unsigned OutDataW   = 56;
  localparam int unsigned OutUserW   = 3;
  localparam int unsigned QueueDepth = 2;

  // Erase counts above this value saturate to it when the command is decoded.
  localparam logic [CountW-1:0] MaxErase = 4'd10;

  // Command codes as they arrive on the input stream.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_ERASE = 2'd1,
    OP_READ  = 2'd2,
    OP_OTHER = 2'd3
  } op_e;

  // Result kinds as they leave on the output stream.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ERASE = 2'd2
  } kind_e;

  // A classified command as it waits in the queue.
  typedef struct packed {
    op_e                op;
    logic [AddrW-1:0]   lba;
    logic [ValueW-1:0]  value;
    logic [CountW-1:0]  count;
  } cmd_t;

  // Handshake between the front end and the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_out_t;

  // One held write or erase; data holds the erase count for an erase.
  typedef struct packed {
    logic               is_erase;
    logic [AddrW-1:0]   addr;
    logic [ValueW-1:0]  data;
  } entry_t;

endpackage

// ===== rtl/core/ssd_write_buffer_with_read_forward_unit.sv =====
`timescale 1ns / 1ps
// A write or erase into a non-full buffer passes through ST_EXEC in the back end.
// A full buffer is first flushed as DEPTH beats, one flushed beat per cycle while the output is free.
// A read searches the held entries newest first, up to DEPTH - 1 of them.
// The back-end sequencer takes a new command only from ST_IDLE, once the last one is done.
// Reset: asynchronous active low; the queue and the buffer come up empty.
// ----------------------------------------------------------------------------
// ssd_write_buffer_with_read_forward_unit
// Write buffer with read forwarding: a decoding front end and a queue feed
// a back end that holds pending writes and erases and answers reads.
// ----------------------------------------------------------------------------
module ssd_write_buffer_with_read_forward_unit
  import ssdwb_pkg::*;
#(
  parameter int unsigned DEPTH = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // Fields from bit 0: command[1:0], lba[17:2], write_value[49:18],
  // erase_count[53:50], zero fill[55:54].
  input  logic [InDataW-1:0]   s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // Fields from bit 0: out_lba[15:0], out_value[47:16], out_count[51:48],
  // zero fill[55:52].
  output logic [OutDataW-1:0]  m_axis_tdata_o,
  // Fields from bit 0: kind[1:0], hit[2].
  output logic [OutUserW-1:0]  m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  queue_out_t queue;
  logic       pop;

  // Front end: accept and decode command beats.
  ssdwb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .queue_o         (queue),
    .pop_i           (pop)
  );

  // Back end: buffer, flush and read search.
  ssdwb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .queue_i         (queue),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== rtl/core/ssdwb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdwb_front
// Accepts command beats, decodes and saturates them, and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module ssdwb_front
  import ssdwb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Fields from bit 0: command[1:0], lba[17:2], write_value[49:18],
  // erase_count[53:50], zero fill[55:54].
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output queue_out_t          queue_o,
  input  logic                pop_i
);

  localparam int unsigned PtrW  = $clog2(QueueDepth);
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  cmd_t             slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  cmd_t             cmd_in;
  logic [CountW-1:0] raw_count;
  logic             push;

  // Decode the beat and clamp the erase count.
  always_comb begin
    raw_count     = s_axis_tdata_i[53:50];
    cmd_in.lba    = s_axis_tdata_i[17:2];
    cmd_in.value  = s_axis_tdata_i[49:18];
    cmd_in.count  = (raw_count > MaxErase) ? MaxErase : raw_count;
    cmd_in.op     = op_e'(s_axis_tdata_i[1:0]);
  end

  assign s_axis_tready_o = (fill_q != FillW'(QueueDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;

  assign queue_o.valid = (fill_q != '0);
  assign queue_o.cmd   = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i && queue_o.valid) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop_i && queue_o.valid})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/core/ssdwb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdwb_back
// Executes queued commands against the entry buffer: flushes a full buffer,
// appends writes and erases, and searches newest first for reads.
// ----------------------------------------------------------------------------
module ssdwb_back
  import ssdwb_pkg::*;
#(
  parameter int unsigned DEPTH = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  queue_out_t           queue_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // Fields from bit 0: out_lba[15:0], out_value[47:16], out_count[51:48],
  // zero fill[55:52].
  output logic [OutDataW-1:0]  m_axis_tdata_o,
  // Fields from bit 0: kind[1:0], hit[2].
  output logic [OutUserW-1:0]  m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_EXEC,
    ST_SEARCH
  } state_e;

  state_e            state_q;
  cmd_t              cur_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   cnt_q;
  entry_t            entries_q [DEPTH];

  logic              out_valid_q;
  kind_e             kind_q;
  logic [AddrW-1:0]  lba_q;
  logic [ValueW-1:0] value_q;
  logic [CountW-1:0] count_q;
  logic              hit_q;
  logic              last_q;

  entry_t            rd_entry;
  logic              out_free;
  logic              out_load;
  logic              match;
  logic [AddrW:0]    erase_end;
  logic              ent_we;
  entry_t            new_entry;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign pop_o    = (state_q == ST_IDLE) && queue_i.valid;

  // Entry under the flush or search index, and its match against the read.
  always_comb begin
    rd_entry  = entries_q[idx_q];
    erase_end = {1'b0, rd_entry.addr} + {{(AddrW + 1 - CountW){1'b0}},
                                         rd_entry.data[CountW-1:0]};
    if (rd_entry.is_erase) begin
      match = (rd_entry.addr <= cur_q.lba) && ({1'b0, cur_q.lba} < erase_end);
    end else begin
      match = (rd_entry.addr == cur_q.lba);
    end
  end

  // A new result beat enters the output register in this cycle.
  always_comb begin
    case (state_q)
      ST_FLUSH:  out_load = out_free;
      ST_EXEC:   out_load = out_free && (cur_q.op == OP_READ) && (cnt_q == '0);
      ST_SEARCH: out_load = out_free && (match || (idx_q == '0));
      default:   out_load = 1'b0;
    endcase
  end

  // Append path for writes and erases.
  always_comb begin
    ent_we             = (state_q == ST_EXEC) &&
                         ((cur_q.op == OP_WRITE) || (cur_q.op == OP_ERASE));
    new_entry.is_erase = (cur_q.op == OP_ERASE);
    new_entry.addr     = cur_q.lba;
    new_entry.data     = (cur_q.op == OP_ERASE) ?
                         {{(ValueW - CountW){1'b0}}, cur_q.count} : cur_q.value;
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entries_q[cnt_q[IdxW-1:0]] <= new_entry;
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_READ;
      lba_q       <= '0;
      value_q     <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (queue_i.valid) begin
            cur_q <= queue_i.cmd;
            idx_q <= '0;
            state_q <= (cnt_q == CntW'(DEPTH)) ? ST_FLUSH : ST_EXEC;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            kind_q      <= rd_entry.is_erase ? KIND_ERASE : KIND_WRITE;
            lba_q       <= rd_entry.addr;
            value_q     <= rd_entry.is_erase ? '0 : rd_entry.data;
            count_q     <= rd_entry.is_erase ? rd_entry.data[CountW-1:0] : '0;
            hit_q       <= 1'b0;
            last_q      <= (idx_q == IdxW'(DEPTH - 1)) && (cur_q.op != OP_READ);
            if (idx_q == IdxW'(DEPTH - 1)) begin
              cnt_q   <= '0;
              state_q <= ST_EXEC;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_EXEC: begin
          case (cur_q.op)
            OP_WRITE, OP_ERASE: begin
              cnt_q   <= cnt_q + 1'b1;
              state_q <= ST_IDLE;
            end
            OP_READ: begin
              if (cnt_q == '0) begin
                if (out_free) begin
                  kind_q      <= KIND_READ;
                  lba_q       <= cur_q.lba;
                  value_q     <= '0;
                  count_q     <= '0;
                  hit_q       <= 1'b0;
                  last_q      <= 1'b1;
                  state_q     <= ST_IDLE;
                end
              end else begin
                idx_q   <= IdxW'(cnt_q - 1'b1);
                state_q <= ST_SEARCH;
              end
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_SEARCH: begin
          if (out_free) begin
            if (match || (idx_q == '0)) begin
              kind_q      <= KIND_READ;
              lba_q       <= cur_q.lba;
              value_q     <= (match && !rd_entry.is_erase) ? rd_entry.data : '0;
              count_q     <= '0;
              hit_q       <= match;
              last_q      <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - AddrW - ValueW - CountW){1'b0}},
                            count_q, value_q, lba_q};
  assign m_axis_tuser_o  = {hit_q, kind_q};
  assign m_axis_tlast_o  = last_q;

endmodule
